// ----- hdl/assert_macros.svh -----
// assertion macros used by the controller rtl file
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define SHSPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define SHSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SHSPC_ASSERT(label, clk, rst_n, prop)
`define SHSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/shspc_pkg.sv -----
// constants, operation codes and the half-step coil table of the stepper controller
// no dependencies
package shspc_pkg;

    localparam int STEPS_PER_REV = 8192;

    localparam int OP_W      = 2;
    localparam int DEG_W     = 16;
    localparam int COIL_W    = 4;
    localparam int POS_OUT_W = 13;

    localparam int DEG_PER_REV = 360;
    localparam int HALF_TURN   = 180;
    // multiple of a full turn that makes every signed angle non-negative
    localparam int DEG_OFFSET  = DEG_PER_REV * 92;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_TICK       = 2'd0;
    localparam t_op OP_SET_TARGET = 2'd1;
    localparam t_op OP_SET_ZERO   = 2'd2;

    function automatic logic [COIL_W-1:0] half_step_coils(input logic [2:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'b1000;
            3'd1:    pat = 4'b1100;
            3'd2:    pat = 4'b0100;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0010;
            3'd5:    pat = 4'b0011;
            3'd6:    pat = 4'b0001;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/stepper_half_step_position_controller.sv -----
// half-step stepper position controller, depends on shspc_pkg and assert_macros.svh
// throughput: one item per cycle while the result side does not stall
// angle reduction, step target scaling and reciprocal divide run in four feed stages;
// the state update and result register form the fifth stage, the only feedback loop
// reset (synchronous, active low): position, target, direction, running cleared,
// coils off, pipeline empty
`include "assert_macros.svh"

module stepper_half_step_position_controller #(
    parameter int STEPS_PER_REV = shspc_pkg::STEPS_PER_REV
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  shspc_pkg::t_op                          i_operation,
    input  logic signed [shspc_pkg::DEG_W-1:0]      i_target_deg,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [shspc_pkg::COIL_W-1:0]            o_coils,
    output logic                                    o_running,
    output logic [shspc_pkg::POS_OUT_W-1:0]         o_position,
    output logic                                    o_clockwise
);

    localparam int DEG_W  = shspc_pkg::DEG_W;
    localparam int OUT_W  = shspc_pkg::POS_OUT_W;
    localparam int DPR    = shspc_pkg::DEG_PER_REV;
    localparam int HALF   = shspc_pkg::HALF_TURN;
    localparam int PW     = $clog2(STEPS_PER_REV);
    localparam int XW     = $clog2(STEPS_PER_REV * DPR);
    localparam int TW     = $clog2(DPR);
    localparam int CW     = DEG_W + 1;

    localparam logic [XW-1:0] RECIP    = XW'((2 ** XW) / DPR);
    localparam logic [XW-1:0] DEG_STEP = XW'(DPR);
    localparam logic [XW-1:0] LAST_X   = XW'((STEPS_PER_REV - 1) * DPR);
    localparam logic [XW-1:0] LO_WRAP  = XW'((HALF + 1) * STEPS_PER_REV);
    localparam logic [XW-1:0] LO_FWD   = XW'((HALF - 1) * STEPS_PER_REV);
    localparam logic [XW-1:0] STEPS_X  = XW'(STEPS_PER_REV);
    localparam logic [PW-1:0] LAST_POS = PW'(STEPS_PER_REV - 1);
    localparam logic [TW-1:0] WRAP_LIM = TW'(HALF - 1);
    localparam logic [CW-1:0] OFFSET_C = CW'(shspc_pkg::DEG_OFFSET);

    // pipeline control
    logic en1, en2, en3, en4, en5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage payloads
    shspc_pkg::t_op  r_op1, r_op2, r_op3, r_op4;
    logic [TW-1:0]   r_t1, r_t2;
    logic [XW-1:0]   r_ts2, r_ts3, r_ts4;
    logic [XW-1:0]   r_lo3, r_lo4;
    logic            r_wrap3, r_wrap4;
    logic [PW-1:0]   r_q3, r_tgt4;

    // controller state, also the result register
    logic [PW-1:0]               r_pos, n_pos;
    logic [XW-1:0]               r_pos_x, n_pos_x;
    logic [PW-1:0]               r_target, n_target;
    logic                        r_cw, n_cw;
    logic                        r_run, n_run;
    logic [shspc_pkg::COIL_W-1:0] r_coil, n_coil;

    logic [CW-1:0]   ang;
    logic [TW-1:0]   n_t;
    logic [2*XW-1:0] prod;
    logic [XW-1:0]   rem;
    logic            dir_cw;
    logic [PW+OUT_W-1:0] pos_ext;
    logic            idle_tick;

    assign en5 = !r_v5 || !i_stall;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    // angle mod 360: offset to non-negative, then restoring subtract of 360*2^k
    always_comb begin
        ang = {{(CW-DEG_W){i_target_deg[DEG_W-1]}}, i_target_deg} + OFFSET_C;
        for (int k = 7; k >= 0; k--) begin
            if (ang >= CW'(DPR << k)) begin
                ang = ang - CW'(DPR << k);
            end
        end
        n_t = ang[TW-1:0];
    end

    // floor(t*steps/360) estimate, low by at most one
    assign prod = {{XW{1'b0}}, r_ts2} * {{XW{1'b0}}, RECIP};
    assign rem  = r_ts3 - XW'(r_q3) * DEG_STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1 <= i_operation;
            r_t1  <= n_t;
        end
        if (en2) begin
            r_op2 <= r_op1;
            r_t2  <= r_t1;
            r_ts2 <= XW'(r_t1) * STEPS_X;
        end
        if (en3) begin
            r_op3   <= r_op2;
            r_ts3   <= r_ts2;
            r_q3    <= prod[XW+PW-1:XW];
            r_wrap3 <= r_t2 < WRAP_LIM;
            r_lo3   <= (r_t2 < WRAP_LIM) ? r_ts2 + LO_WRAP : r_ts2 - LO_FWD;
        end
        if (en4) begin
            r_op4   <= r_op3;
            r_ts4   <= r_ts3;
            r_lo4   <= r_lo3;
            r_wrap4 <= r_wrap3;
            r_tgt4  <= r_q3 + PW'(rem >= DEG_STEP);
        end
    end

    // clockwise when the current degree lies 1..179 below the target, compared
    // in units of degree*steps so no divide by the step count is needed
    always_comb begin
        if (r_wrap4) begin
            dir_cw = (r_pos_x < r_ts4) || (r_pos_x >= r_lo4);
        end else begin
            dir_cw = (r_pos_x < r_ts4) && (r_pos_x >= r_lo4);
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_pos_x  = r_pos_x;
        n_target = r_target;
        n_cw     = r_cw;
        n_run    = r_run;
        n_coil   = r_coil;
        unique case (r_op4)
            shspc_pkg::OP_SET_TARGET: begin
                n_target = r_tgt4;
                n_cw     = dir_cw;
                n_run    = 1'b1;
            end
            shspc_pkg::OP_SET_ZERO: begin
                n_pos   = '0;
                n_pos_x = '0;
            end
            shspc_pkg::OP_TICK: begin
                if (r_run) begin
                    if (r_target == r_pos) begin
                        n_coil = '0;
                        n_run  = 1'b0;
                    end else if (r_cw) begin
                        n_coil = shspc_pkg::half_step_coils(r_pos[2:0]);
                        if (r_pos == LAST_POS) begin
                            n_pos   = '0;
                            n_pos_x = '0;
                        end else begin
                            n_pos   = r_pos + PW'(1);
                            n_pos_x = r_pos_x + DEG_STEP;
                        end
                    end else begin
                        n_coil = shspc_pkg::half_step_coils(r_pos[2:0] - 3'd1);
                        if (r_pos == '0) begin
                            n_pos   = LAST_POS;
                            n_pos_x = LAST_X;
                        end else begin
                            n_pos   = r_pos - PW'(1);
                            n_pos_x = r_pos_x - DEG_STEP;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_pos_x  <= '0;
            r_target <= '0;
            r_cw     <= 1'b0;
            r_run    <= 1'b0;
            r_coil   <= '0;
        end else if (en5 && r_v4) begin
            r_pos    <= n_pos;
            r_pos_x  <= n_pos_x;
            r_target <= n_target;
            r_cw     <= n_cw;
            r_run    <= n_run;
            r_coil   <= n_coil;
        end
    end

    assign pos_ext     = {{OUT_W{1'b0}}, r_pos};
    assign o_valid     = r_v5;
    assign o_coils     = r_coil;
    assign o_running   = r_run;
    assign o_position  = pos_ext[OUT_W-1:0];
    assign o_clockwise = r_cw;

    assign idle_tick = en5 && r_v4 && (r_op4 == shspc_pkg::OP_TICK) && !r_run;

    // scaled position register tracks position times 360
    `SHSPC_ASSERT(a_pos_scaled, i_clk, i_rst_n, r_pos_x == XW'(r_pos) * DEG_STEP)

    // a tick while stopped leaves position and coils alone
    `SHSPC_ASSERT_NEXT(a_idle_tick, i_clk, i_rst_n, idle_tick, $stable(r_pos) && $stable(r_coil))

    // stopping always drops the coils
    `SHSPC_ASSERT(a_stop_coils_off, i_clk, i_rst_n, !$fell(r_run) || (r_coil == '0))

endmodule

// ----- tb/shspc_drive_checker.sv -----
`timescale 1ns / 100ps
// watches both channels of the stepper controller, predicts each result and compares it
// depends on shspc_pkg
module shspc_drive_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  shspc_pkg::t_op                       i_operation,
    input  logic signed [shspc_pkg::DEG_W-1:0]   i_target_deg,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [shspc_pkg::COIL_W-1:0]         i_coils,
    input  logic                                 i_running,
    input  logic [shspc_pkg::POS_OUT_W-1:0]      i_position,
    input  logic                                 i_clockwise,
    output int                                   o_mismatches,
    output int                                   o_pending
);

    localparam int DEG_W         = shspc_pkg::DEG_W;
    localparam int COIL_W        = shspc_pkg::COIL_W;
    localparam int POS_OUT_W     = shspc_pkg::POS_OUT_W;
    localparam int DEG_PER_REV   = shspc_pkg::DEG_PER_REV;
    localparam int HALF_TURN     = shspc_pkg::HALF_TURN;
    localparam int STEPS_PER_REV = shspc_pkg::STEPS_PER_REV;

    localparam shspc_pkg::t_op OP_TICK       = shspc_pkg::OP_TICK;
    localparam shspc_pkg::t_op OP_SET_TARGET = shspc_pkg::OP_SET_TARGET;
    localparam shspc_pkg::t_op OP_SET_ZERO   = shspc_pkg::OP_SET_ZERO;

    typedef struct packed {
        logic [COIL_W-1:0]    coils;
        logic                 running;
        logic [POS_OUT_W-1:0] position;
        logic                 clockwise;
    } t_drive_state;

    localparam logic [COIL_W-1:0] HALF_STEP_SEQ [8] = '{
        4'b1000, 4'b1100, 4'b0100, 4'b0110, 4'b0010, 4'b0011, 4'b0001, 4'b1001
    };

    logic [POS_OUT_W-1:0] pos_steps;
    logic [POS_OUT_W-1:0] goal_steps;
    logic                 turn_cw;
    logic                 moving;
    logic [COIL_W-1:0]    coil_drive;

    t_drive_state expected_drive [$];

    // applies one command to the motor state and returns what the outputs show afterward
    function automatic t_drive_state advance_motor(input shspc_pkg::t_op op,
                                                   input logic signed [DEG_W-1:0] deg);
        int           angle;
        int           now_deg;
        int           diff;
        logic [2:0]   idx;
        t_drive_state r;
        case (op)
            OP_SET_TARGET: begin
                angle = int'(deg) % DEG_PER_REV;
                if (angle < 0) angle += DEG_PER_REV;
                now_deg    = (int'(pos_steps) * DEG_PER_REV) / STEPS_PER_REV;
                goal_steps = POS_OUT_W'((angle * STEPS_PER_REV) / DEG_PER_REV);
                // shortest way round, a half turn exactly counts as anticlockwise
                diff = angle - now_deg;
                if (diff < -HALF_TURN) diff += DEG_PER_REV;
                if (diff >= HALF_TURN) diff -= DEG_PER_REV;
                turn_cw = (diff > 0);
                moving  = 1'b1;
            end
            OP_SET_ZERO: begin
                pos_steps = '0;
            end
            OP_TICK: begin
                if (moving) begin
                    if (goal_steps == pos_steps) begin
                        coil_drive = '0;
                        moving     = 1'b0;
                    end else if (turn_cw) begin
                        coil_drive = HALF_STEP_SEQ[pos_steps[2:0]];
                        pos_steps  = POS_OUT_W'((int'(pos_steps) + 1) % STEPS_PER_REV);
                    end else begin
                        idx        = pos_steps[2:0] - 3'd1;
                        coil_drive = HALF_STEP_SEQ[idx];
                        pos_steps  = POS_OUT_W'((int'(pos_steps) + STEPS_PER_REV - 1)
                                                % STEPS_PER_REV);
                    end
                end
            end
            default: begin
            end
        endcase
        r.coils     = coil_drive;
        r.running   = moving;
        r.position  = pos_steps;
        r.clockwise = turn_cw;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_drive_state want;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            pos_steps  = '0;
            goal_steps = '0;
            turn_cw    = 1'b0;
            moving     = 1'b0;
            coil_drive = '0;
            expected_drive.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_drive.size() == 0) begin
                    $error("result transfer with nothing expected: coils %0h position %0d",
                           i_coils, i_position);
                    errs++;
                end else begin
                    want = expected_drive.pop_front();
                    if (i_coils !== want.coils) begin
                        $error("coils: expected %0h, actual %0h", want.coils, i_coils);
                        errs++;
                    end
                    if (i_running !== want.running) begin
                        $error("running: expected %0d, actual %0d", want.running, i_running);
                        errs++;
                    end
                    if (i_position !== want.position) begin
                        $error("position: expected %0d, actual %0d", want.position,
                               i_position);
                        errs++;
                    end
                    if (i_clockwise !== want.clockwise) begin
                        $error("clockwise: expected %0d, actual %0d", want.clockwise,
                               i_clockwise);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_drive.push_back(advance_motor(i_operation, i_target_deg));
        end
        o_mismatches <= i_rst_n ? o_mismatches + errs : 0;
        o_pending    <= expected_drive.size();
    end

endmodule

// ----- tb/stepper_half_step_position_controller_tb.sv -----
`timescale 1ns / 100ps
// stimulus and verdict for the stepper half-step position controller
// depends on shspc_pkg, the controller rtl and shspc_drive_checker
module stepper_half_step_position_controller_tb;

    localparam int DEG_W       = shspc_pkg::DEG_W;
    localparam int DEG_PER_REV = shspc_pkg::DEG_PER_REV;

    localparam shspc_pkg::t_op OP_TICK       = shspc_pkg::OP_TICK;
    localparam shspc_pkg::t_op OP_SET_TARGET = shspc_pkg::OP_SET_TARGET;
    localparam shspc_pkg::t_op OP_SET_ZERO   = shspc_pkg::OP_SET_ZERO;

    localparam shspc_pkg::t_op OP_UNUSED     = 2'd3;
    localparam int  HOLD_CYCLES   = 120;
    localparam int  QUIET_LIMIT   = 2000;
    localparam int  DRAIN_CYCLES  = 10;

    logic                                   i_clk        = 1'b0;
    logic                                   i_rst_n      = 1'b0;
    logic                                   i_valid      = 1'b0;
    shspc_pkg::t_op                         i_operation  = shspc_pkg::OP_TICK;
    logic signed [DEG_W-1:0]                i_target_deg = '0;
    logic                                   i_stall      = 1'b0;
    logic                                   o_stall;
    logic                                   o_valid;
    logic [shspc_pkg::COIL_W-1:0]           o_coils;
    logic                                   o_running;
    logic [shspc_pkg::POS_OUT_W-1:0]        o_position;
    logic                                   o_clockwise;

    int mismatches;
    int pending;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int quiet_cycles   = 0;

    always #1 i_clk = ~i_clk;

    stepper_half_step_position_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_target_deg (i_target_deg),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_coils      (o_coils),
        .o_running    (o_running),
        .o_position   (o_position),
        .o_clockwise  (o_clockwise)
    );

    shspc_drive_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_operation  (i_operation),
        .i_target_deg (i_target_deg),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_coils      (o_coils),
        .i_running    (o_running),
        .i_position   (o_position),
        .i_clockwise  (o_clockwise),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // result side: random stall, or a long hold-off when the stimulus asks for one
    initial begin
        int holds_done;
        int n;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= (int'($urandom_range(99)) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one command transfer, with random gaps in front of it
    task automatic offer(input shspc_pkg::t_op op, input logic signed [DEG_W-1:0] deg);
        while (int'($urandom_range(99)) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_target_deg <= deg;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // moves toward targets a few degrees off a whole turn, so most of them end in a stop
    task automatic random_moves(input int n_items);
        int                      sent;
        int                      ticks;
        int                      k;
        int                      r;
        logic signed [DEG_W-1:0] deg;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 55) begin
                offer(OP_SET_ZERO, DEG_W'($urandom));
                sent++;
            end
            if ($urandom_range(99) < 75)
                deg = DEG_W'(int'($urandom_range(6)) - 3
                             + DEG_PER_REV * (int'($urandom_range(181)) - 91));
            else
                deg = DEG_W'($urandom);
            offer(OP_SET_TARGET, deg);
            sent++;
            ticks = $urandom_range(90, 5);
            for (k = 0; k < ticks; k++) begin
                r = $urandom_range(99);
                if (r < 4)
                    offer(OP_UNUSED, DEG_W'($urandom));
                else if (r < 6)
                    offer(OP_SET_ZERO, DEG_W'($urandom));
                else if (r < 8)
                    offer(OP_SET_TARGET, DEG_W'(int'($urandom_range(8)) - 4));
                else
                    offer(OP_TICK, DEG_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stopped ticks, already at target, wrap of angles, set while running,
        // anticlockwise step out of zero, half-turn tie
        offer(OP_TICK, DEG_W'(0));
        offer(OP_UNUSED, DEG_W'(32767));
        offer(OP_SET_TARGET, DEG_W'(0));
        offer(OP_TICK, DEG_W'(-1));
        offer(OP_TICK, DEG_W'(0));
        offer(OP_SET_TARGET, DEG_W'(32767));
        repeat (4) offer(OP_TICK, DEG_W'(0));
        offer(OP_SET_TARGET, DEG_W'(-32768));
        repeat (3) offer(OP_TICK, DEG_W'(0));
        offer(OP_SET_ZERO, DEG_W'(-1));
        offer(OP_TICK, DEG_W'(0));
        offer(OP_TICK, DEG_W'(0));
        offer(OP_SET_TARGET, DEG_W'(359));
        offer(OP_SET_ZERO, DEG_W'(0));
        offer(OP_SET_TARGET, DEG_W'(180));
        offer(OP_TICK, DEG_W'(0));
        offer(OP_TICK, DEG_W'(0));
        offer(OP_SET_TARGET, DEG_W'(-180));
        offer(OP_SET_TARGET, DEG_W'(179));
        offer(OP_SET_TARGET, DEG_W'(1));
        repeat (3) offer(OP_TICK, DEG_W'(0));
        offer(OP_UNUSED, DEG_W'(-32768));
        wait_drained();

        send_gap_pct   = 17;
        recv_stall_pct <= 85;
        random_moves(560);
        wait_drained();

        send_gap_pct   = 85;
        recv_stall_pct <= 17;
        random_moves(560);
        wait_drained();

        send_gap_pct   = 0;
        recv_stall_pct <= 0;
        hold_requests  <= hold_requests + 1;
        random_moves(560);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
